>>> rtl/yfts_pkg.sv
// Shared types and constants of the YAML flow token scanner.
package yfts_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    typedef enum logic [3:0] {
        TK_SCALAR = 4'd0,
        TK_LBRACK = 4'd1,
        TK_LBRACE = 4'd2,
        TK_RBRACK = 4'd3,
        TK_RBRACE = 4'd4,
        TK_COMMA  = 4'd5,
        TK_COLON  = 4'd6,
        TK_BULLET = 4'd7,
        TK_ERROR  = 4'd8,
        TK_END    = 4'd9
    } t_token_kind;

    typedef enum logic [3:0] {
        CL_OTHER,
        CL_SQUOTE,
        CL_DQUOTE,
        CL_LBRACK,
        CL_LBRACE,
        CL_RBRACK,
        CL_RBRACE,
        CL_COMMA,
        CL_COLON,
        CL_DASH,
        CL_SPACE,
        CL_TAB,
        CL_CR,
        CL_LF,
        CL_BACKSLASH,
        CL_NUL
    } t_byte_class;

    typedef struct packed {
        logic [7:0] text_byte;
        logic       is_last;
    } t_in_item;

    typedef struct packed {
        logic [3:0] token_kind;
        logic       last_of_run;
    } t_out_item;

    typedef struct packed {
        t_byte_class byte_class;
        logic        is_last;
    } t_q_item;

    typedef struct packed {
        logic               error_seen;
        logic [DEPTH_W-1:0] depth;
    } t_back_status;

endpackage

>>> rtl/yfts_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module yfts_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

>>> rtl/yfts_front.sv
// Front part: classifies each incoming byte and holds it in a two-entry queue.
module yfts_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  yfts_pkg::t_in_item i_in_item,
    output logic              o_q_valid,
    input  logic              i_q_pop,
    output yfts_pkg::t_q_item o_q_item
);
    import yfts_pkg::*;

    localparam logic [7:0] CH_SQUOTE    = 8'h27;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_LBRACK    = 8'h5B;
    localparam logic [7:0] CH_LBRACE    = 8'h7B;
    localparam logic [7:0] CH_RBRACK    = 8'h5D;
    localparam logic [7:0] CH_RBRACE    = 8'h7D;
    localparam logic [7:0] CH_COMMA     = 8'h2C;
    localparam logic [7:0] CH_COLON     = 8'h3A;
    localparam logic [7:0] CH_DASH      = 8'h2D;
    localparam logic [7:0] CH_SPACE     = 8'h20;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_LF        = 8'h0A;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_NUL       = 8'h00;

    t_q_item     r_slot [2];
    logic        r_wr_ptr;
    logic        r_rd_ptr;
    logic [1:0]  r_count;
    logic        push;
    t_byte_class cls;

    always_comb begin
        case (i_in_item.text_byte)
            CH_SQUOTE:    cls = CL_SQUOTE;
            CH_DQUOTE:    cls = CL_DQUOTE;
            CH_LBRACK:    cls = CL_LBRACK;
            CH_LBRACE:    cls = CL_LBRACE;
            CH_RBRACK:    cls = CL_RBRACK;
            CH_RBRACE:    cls = CL_RBRACE;
            CH_COMMA:     cls = CL_COMMA;
            CH_COLON:     cls = CL_COLON;
            CH_DASH:      cls = CL_DASH;
            CH_SPACE:     cls = CL_SPACE;
            CH_TAB:       cls = CL_TAB;
            CH_CR:        cls = CL_CR;
            CH_LF:        cls = CL_LF;
            CH_BACKSLASH: cls = CL_BACKSLASH;
            CH_NUL:       cls = CL_NUL;
            default:      cls = CL_OTHER;
        endcase
    end

    assign o_in_stall = (r_count == 2'd2);
    assign push       = i_in_valid && !o_in_stall;
    assign o_q_valid  = (r_count != 2'd0);
    assign o_q_item   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= '{byte_class: cls, is_last: i_in_item.is_last};
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (push) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_q_pop) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            if (push && !i_q_pop) begin
                r_count <= r_count + 2'd1;
            end else if (!push && i_q_pop) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

>>> rtl/yfts_back.sv
// Back part: quote and nesting state, bracket stack and the token buffer.
module yfts_back (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_valid,
    input  yfts_pkg::t_q_item      i_q_item,
    output logic                   o_q_pop,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output yfts_pkg::t_out_item    o_out_item,
    output yfts_pkg::t_back_status o_status
);
    import yfts_pkg::*;

    logic               r_error_seen, n_error_seen;
    logic               r_in_single, n_in_single;
    logic               r_in_double, n_in_double;
    logic               r_close_pending, n_close_pending;
    logic               r_skip_next, n_skip_next;
    logic               r_line_start, n_line_start;
    logic               r_colon_seen, n_colon_seen;
    logic [DEPTH_W-1:0] r_depth, n_depth;
    logic               r_top, n_top;
    logic               r_hold, n_hold;
    logic               r_use_hold, n_use_hold;
    t_token_kind        r_tok [3];
    t_token_kind        n_tok [3];
    logic [1:0]         r_cnt, n_cnt;
    logic [1:0]         r_idx, n_idx;

    logic               below;
    logic               ram_rdata;
    logic               ram_we;
    logic               out_fire;
    logic               buf_free;
    logic               blank;
    logic               consumed;
    logic               push_req, push_brace, pop_req;
    logic [3:0]         cand_v;
    t_token_kind        cand_k [4];
    logic [1:0]         ecnt;

    assign below       = r_use_hold ? r_hold : ram_rdata;
    assign o_out_valid = (r_idx != r_cnt);
    assign out_fire    = o_out_valid && !i_out_stall;
    assign buf_free    = (r_idx == r_cnt) || (out_fire && (r_idx + 2'd1 == r_cnt));
    assign o_q_pop     = i_q_valid && buf_free;

    assign o_out_item.token_kind  = r_tok[r_idx];
    assign o_out_item.last_of_run = (r_idx + 2'd1 == r_cnt);
    assign o_status.error_seen    = r_error_seen;
    assign o_status.depth         = r_depth;

    assign ram_we = push_req && (r_depth != DEPTH_W'(STACK_DEPTH)) && (r_depth != '0);

    yfts_ram #(
        .WIDTH (1),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ADDR_W'(r_depth - DEPTH_W'(1))),
        .i_wdata (r_top),
        .i_raddr (ADDR_W'(n_depth - DEPTH_W'(2))),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_error_seen    = r_error_seen;
        n_in_single     = r_in_single;
        n_in_double     = r_in_double;
        n_close_pending = r_close_pending;
        n_skip_next     = r_skip_next;
        n_line_start    = r_line_start;
        n_colon_seen    = r_colon_seen;
        n_depth         = r_depth;
        n_top           = r_top;
        n_hold          = r_hold;
        n_use_hold      = 1'b0;
        consumed        = 1'b0;
        push_req        = 1'b0;
        push_brace      = 1'b0;
        pop_req         = 1'b0;
        cand_v          = '0;
        cand_k[0]       = TK_SCALAR;
        cand_k[1]       = TK_SCALAR;
        cand_k[2]       = TK_SCALAR;
        cand_k[3]       = TK_END;
        blank           = i_q_item.byte_class inside {CL_SPACE, CL_LF, CL_CR, CL_TAB, CL_NUL};

        if (o_q_pop && !r_error_seen) begin
            // A held closing quote followed by another quote is an escaped quote.
            if (r_close_pending) begin
                n_close_pending = 1'b0;
                if (i_q_item.byte_class == CL_SQUOTE) begin
                    consumed = 1'b1;
                end else begin
                    n_in_single = 1'b0;
                    cand_v[3]   = 1'b1;
                end
            end
            if (!consumed) begin
                if (r_colon_seen && !blank && (r_depth == '0)) begin
                    n_colon_seen = 1'b0;
                    n_error_seen = 1'b1;
                    cand_v[2]    = 1'b1;
                    cand_k[1]    = TK_ERROR;
                end else begin
                    n_colon_seen = 1'b0;
                    if (n_in_single) begin
                        if (i_q_item.byte_class == CL_SQUOTE) begin
                            n_close_pending = 1'b1;
                        end
                    end else if (r_in_double) begin
                        if (r_skip_next) begin
                            n_skip_next = 1'b0;
                        end else if (i_q_item.byte_class == CL_BACKSLASH) begin
                            n_skip_next = 1'b1;
                        end else if (i_q_item.byte_class == CL_DQUOTE) begin
                            n_in_double = 1'b0;
                            cand_v[2]   = 1'b1;
                            cand_k[1]   = TK_SCALAR;
                        end
                    end else if (r_line_start && (i_q_item.byte_class == CL_TAB)) begin
                        n_error_seen = 1'b1;
                        cand_v[2]    = 1'b1;
                        cand_k[1]    = TK_ERROR;
                    end else if (i_q_item.byte_class == CL_LF) begin
                        n_line_start = 1'b1;
                    end else if (!(i_q_item.byte_class inside {CL_SPACE, CL_TAB, CL_CR})) begin
                        n_line_start = 1'b0;
                        case (i_q_item.byte_class)
                            CL_SQUOTE: n_in_single = 1'b1;
                            CL_DQUOTE: n_in_double = 1'b1;
                            CL_LBRACK: begin
                                push_req  = 1'b1;
                                cand_v[2] = 1'b1;
                                cand_k[1] = TK_LBRACK;
                            end
                            CL_LBRACE: begin
                                push_req   = 1'b1;
                                push_brace = 1'b1;
                                cand_v[2]  = 1'b1;
                                cand_k[1]  = TK_LBRACE;
                            end
                            CL_RBRACK, CL_RBRACE: begin
                                cand_v[2] = 1'b1;
                                if ((r_depth != '0) &&
                                    (r_top == (i_q_item.byte_class == CL_RBRACE))) begin
                                    pop_req   = 1'b1;
                                    cand_k[1] = (i_q_item.byte_class == CL_RBRACE) ?
                                                TK_RBRACE : TK_RBRACK;
                                end else begin
                                    n_error_seen = 1'b1;
                                    cand_k[1]    = TK_ERROR;
                                end
                            end
                            CL_COMMA: begin
                                cand_v[2] = 1'b1;
                                cand_k[1] = TK_COMMA;
                            end
                            CL_COLON: begin
                                n_colon_seen = 1'b1;
                                cand_v[2]    = 1'b1;
                                cand_k[1]    = TK_COLON;
                            end
                            CL_DASH: begin
                                cand_v[2] = 1'b1;
                                cand_k[1] = TK_BULLET;
                            end
                            default: ;
                        endcase
                    end
                end
            end

            // Stack update: the top entry lives in a register, the rest in RAM.
            if (push_req && (r_depth != DEPTH_W'(STACK_DEPTH))) begin
                n_depth    = r_depth + DEPTH_W'(1);
                n_top      = push_brace;
                n_hold     = r_top;
                n_use_hold = (r_depth != '0);
            end else if (pop_req) begin
                n_depth = r_depth - DEPTH_W'(1);
                n_top   = below;
            end

            if (i_q_item.is_last && !n_error_seen) begin
                if (n_close_pending) begin
                    n_close_pending = 1'b0;
                    n_in_single     = 1'b0;
                    cand_v[1]       = 1'b1;
                end
                cand_v[0] = 1'b1;
                if (n_in_single || n_in_double || (n_depth != '0)) begin
                    n_error_seen = 1'b1;
                    cand_k[3]    = TK_ERROR;
                end
            end
        end

        if (o_q_pop && i_q_item.is_last) begin
            n_error_seen    = 1'b0;
            n_in_single     = 1'b0;
            n_in_double     = 1'b0;
            n_close_pending = 1'b0;
            n_skip_next     = 1'b0;
            n_line_start    = 1'b1;
            n_colon_seen    = 1'b0;
            n_depth         = '0;
            n_use_hold      = 1'b0;
        end
    end

    // Token order: held scalar, scanned token, final scalar, then end or error.
    always_comb begin
        n_tok[0] = r_tok[0];
        n_tok[1] = r_tok[1];
        n_tok[2] = r_tok[2];
        n_cnt    = r_cnt;
        n_idx    = r_idx;
        ecnt     = 2'd0;
        if (out_fire) begin
            n_idx = r_idx + 2'd1;
        end
        if (o_q_pop) begin
            for (int i = 3; i >= 0; i--) begin
                if (cand_v[i]) begin
                    case (ecnt)
                        2'd0:    n_tok[0] = cand_k[3-i];
                        2'd1:    n_tok[1] = cand_k[3-i];
                        default: n_tok[2] = cand_k[3-i];
                    endcase
                    ecnt = ecnt + 2'd1;
                end
            end
            n_cnt = ecnt;
            n_idx = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_hold   <= n_hold;
        r_tok[0] <= n_tok[0];
        r_tok[1] <= n_tok[1];
        r_tok[2] <= n_tok[2];
        if (!i_rst_n) begin
            r_error_seen    <= 1'b0;
            r_in_single     <= 1'b0;
            r_in_double     <= 1'b0;
            r_close_pending <= 1'b0;
            r_skip_next     <= 1'b0;
            r_line_start    <= 1'b1;
            r_colon_seen    <= 1'b0;
            r_depth         <= '0;
            r_use_hold      <= 1'b0;
            r_cnt           <= 2'd0;
            r_idx           <= 2'd0;
        end else begin
            r_error_seen    <= n_error_seen;
            r_in_single     <= n_in_single;
            r_in_double     <= n_in_double;
            r_close_pending <= n_close_pending;
            r_skip_next     <= n_skip_next;
            r_line_start    <= n_line_start;
            r_colon_seen    <= n_colon_seen;
            r_depth         <= n_depth;
            r_use_hold      <= n_use_hold;
            r_cnt           <= n_cnt;
            r_idx           <= n_idx;
        end
    end

endmodule

>>> rtl/yaml_flow_token_scanner_top.sv
// Top level of the YAML flow token scanner: front classifier, queue and back scanner.
// An accepted byte is registered in the two-entry queue, then its tokens are registered in
// the three-entry token buffer, from which they are offered at the output.
// Throughput: one byte per cycle while each byte yields at most one token and the output
// is not stalled; a byte that yields more tokens holds the back part until all are sent.
// Reset (synchronous, active low) clears the queue, scan state and token buffer at once;
// the bracket stack RAM is not cleared, since only entries written in the run are read.
module yaml_flow_token_scanner_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_stall,
    input  yfts_pkg::t_in_item  i_in_item,
    output logic                o_out_valid,
    input  logic                i_out_stall,
    output yfts_pkg::t_out_item o_out_item
);
    import yfts_pkg::*;

    // Classified bytes pass from the front part to the back part through a
    // two-entry queue, so that an input transfer can still be taken while
    // the back part waits on a stalled output transfer.
    logic         q_valid;
    logic         q_pop;
    t_q_item      q_item;
    t_back_status status;

    yfts_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_item  (i_in_item),
        .o_q_valid  (q_valid),
        .i_q_pop    (q_pop),
        .o_q_item   (q_item)
    );

    // The back part keeps the quote, line and nesting state. The top of the
    // bracket stack is held in a register and the levels beneath it in RAM,
    // so a close can be checked in the same cycle as it arrives. Tokens of
    // one byte are buffered and leave one per output transfer.
    yfts_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_item    (q_item),
        .o_q_pop     (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .o_status    (status)
    );

    // An error or end token always closes the run of tokens of its byte.
    a_final_token_last : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && ((o_out_item.token_kind == TK_ERROR) ||
                        (o_out_item.token_kind == TK_END))
        |-> o_out_item.last_of_run)
        else $error("error or end token not marked as last of its run");

    // Once an error is latched, the nesting depth is frozen until the run ends.
    a_depth_frozen : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(status.error_seen) && status.error_seen |-> $stable(status.depth))
        else $error("nesting depth changed after an error");

    // The depth moves by one level at most, or returns to zero at the end of a run.
    a_depth_step : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.depth != $past(status.depth) |->
            (status.depth == $past(status.depth) + DEPTH_W'(1)) ||
            (status.depth == $past(status.depth) - DEPTH_W'(1)) ||
            (status.depth == '0))
        else $error("nesting depth jumped");

    // The depth never exceeds the stack size.
    a_depth_bound : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (status.depth <= DEPTH_W'(STACK_DEPTH)))
        else $error("nesting depth beyond stack size");

endmodule
